// ----- sv/mqtt_hp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT header parser package
// Shared widths, codes and the result record of the MQTT fixed-header parser.
// ----------------------------------------------------------------------------
package mqtt_hp_pkg;

  // Width of the saturating byte position counter
  localparam int POS_BITS = 16;

  // Width for position compares: holds the saturated size and the
  // end of a 16-bit length field past a five-byte fixed header
  localparam int CMP_W = ((POS_BITS > 17) ? POS_BITS : 17) + 1;

  localparam int LEN_MAX_BYTES    = 4;
  localparam int CONNECT_NAME_MAX = 16;

  typedef enum logic [1:0] {
    LEN_DECODING = 2'd0,
    LEN_DONE     = 2'd1,
    LEN_FAILED   = 2'd2
  } len_status_t;

  typedef enum logic [1:0] {
    DETAIL_NONE    = 2'd0,
    DETAIL_CONNECT = 2'd1,
    DETAIL_PUBLISH = 2'd2
  } detail_kind_t;

  localparam logic [3:0] PTYPE_RESERVED = 4'd0;
  localparam logic [3:0] PTYPE_CONNECT  = 4'd1;
  localparam logic [3:0] PTYPE_PUBLISH  = 4'd3;

  localparam logic [15:0] PORT_PLAIN_RST  = 16'd1883;
  localparam logic [15:0] PORT_SECURE_RST = 16'd8883;

  // Register index, taken from paddr[2]
  localparam logic REG_PORT_PLAIN  = 1'b0;
  localparam logic REG_PORT_SECURE = 1'b1;

  typedef struct packed {
    logic         accepted;
    logic [3:0]   packet_type;
    logic [3:0]   header_flags;
    logic [27:0]  remaining_length;
    detail_kind_t detail_kind;
    logic [2:0]   text_offset;
    logic [7:0]   text_length;
    logic [7:0]   protocol_level;
    logic         level_present;
    logic [1:0]   qos;
  } result_t;

endpackage

// ----- sv/mqtt_header_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT fixed-header parser core
// Recognizes MQTT traffic in a TCP payload stream and reports one summary
// transaction per segment.
// ----------------------------------------------------------------------------
// The core takes one TCP payload byte per clock on the slave stream and
// sustains one byte every cycle while s_tready is high; all per-byte work
// is a single pass of short logic from the parse state registers back into
// themselves. On the byte flagged as first it samples is_tcp and both ports
// and restarts the segment; on the byte carrying tlast it produces one summary
// transaction, which is registered into the output buffer for the master stream.
// Results pass through a two-entry output buffer, so the input keeps
// flowing while one result waits; s_tready drops only when both entries
// are full. Rejected segments report accepted=0 with all other fields zero.
// The two recognized ports sit in APB registers at 0x0 and 0x4 (low 16 bits).
// ----------------------------------------------------------------------------
module mqtt_header_parser_core
  import mqtt_hp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] data_byte, [23:8] source_port, [39:24] dest_port
  input  logic [39:0] s_tdata,
  // [0] first, [1] is_tcp
  input  logic [1:0]  s_tuser,
  input  logic        s_tlast,

  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] packet_type, [7:4] header_flags, [35:8] remaining_length,
  // [38:36] text_offset, [46:39] text_length, [54:47] protocol_level,
  // [56:55] qos, [63:57] zero
  output logic [63:0] m_tdata,
  // [0] accepted, [2:1] detail_kind, [3] level_present
  output logic [3:0]  m_tuser,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Configuration registers
  logic [15:0] port_plain;
  logic [15:0] port_secure;

  // Segment parse state
  logic [POS_BITS-1:0] byte_position, byte_position_next;
  logic                port_matched,  port_matched_next;
  logic [7:0]          type_and_flags, type_and_flags_next;
  logic [27:0]         length_accumulator, length_accumulator_next;
  logic [2:0]          length_bytes_used, length_bytes_used_next;
  len_status_t         length_status, length_status_next;
  logic [15:0]         string_length, string_length_next;
  logic [7:0]          level_byte, level_byte_next;

  // Output buffer: head register plus one skid entry
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  logic    in_fire;
  logic    out_fire;
  logic    push;
  result_t result;

  // Input field views
  logic [7:0]  data_byte;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic        first;
  logic        is_tcp;

  assign data_byte   = s_tdata[7:0];
  assign source_port = s_tdata[23:8];
  assign dest_port   = s_tdata[39:24];
  assign first       = s_tuser[0];
  assign is_tcp      = s_tuser[1];

  assign s_tready = !skid_valid;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign push     = in_fire && s_tlast;

  // --------------------------------------------------------------------------
  // APB register port: writes land on the access phase, reads are direct.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_PORT_PLAIN:  prdata = {16'h0000, port_plain};
      REG_PORT_SECURE: prdata = {16'h0000, port_secure};
      default:         prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_plain  <= PORT_PLAIN_RST;
      port_secure <= PORT_SECURE_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_PORT_PLAIN:  port_plain  <= pwdata[15:0];
        REG_PORT_SECURE: port_secure <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Per-byte state update. A first-marked byte restarts the segment before
  // it is parsed itself.
  // --------------------------------------------------------------------------
  logic [POS_BITS-1:0] cur_position;
  logic                cur_matched;
  logic [7:0]          cur_taf;
  logic [27:0]         cur_acc;
  logic [2:0]          cur_used;
  len_status_t         cur_status;
  logic [15:0]         cur_slen;
  logic [7:0]          cur_level;
  logic [CMP_W-1:0]    idx_c;
  logic [CMP_W-1:0]    body_c;
  logic [4:0]          shift_amt;

  always_comb begin
    cur_position = first ? '0 : byte_position;
    cur_matched  = first ? (is_tcp &&
                            (source_port == port_plain || source_port == port_secure ||
                             dest_port == port_plain || dest_port == port_secure))
                         : port_matched;
    cur_taf      = first ? 8'h00 : type_and_flags;
    cur_acc      = first ? 28'h0 : length_accumulator;
    cur_used     = first ? 3'd0 : length_bytes_used;
    cur_status   = first ? LEN_DECODING : length_status;
    cur_slen     = first ? 16'h0000 : string_length;
    cur_level    = first ? 8'h00 : level_byte;

    idx_c  = CMP_W'(cur_position);
    body_c = CMP_W'(cur_used) + CMP_W'(1);

    // Seven payload bits per length byte, least significant group first
    case (cur_used[1:0])
      2'd0:    shift_amt = 5'd0;
      2'd1:    shift_amt = 5'd7;
      2'd2:    shift_amt = 5'd14;
      default: shift_amt = 5'd21;
    endcase

    byte_position_next      = cur_position;
    port_matched_next       = cur_matched;
    type_and_flags_next     = cur_taf;
    length_accumulator_next = cur_acc;
    length_bytes_used_next  = cur_used;
    length_status_next      = cur_status;
    string_length_next      = cur_slen;
    level_byte_next         = cur_level;

    // Nothing is captured once the position has saturated
    if (cur_position != POS_MAX) begin
      if (cur_position == '0) begin
        type_and_flags_next = data_byte;
      end else if (cur_status == LEN_DECODING) begin
        length_accumulator_next = cur_acc + (28'(data_byte[6:0]) << shift_amt);
        length_bytes_used_next  = cur_used + 3'd1;
        if (!data_byte[7]) begin
          length_status_next = LEN_DONE;
        end else if (length_bytes_used_next >= 3'(LEN_MAX_BYTES)) begin
          length_status_next = LEN_FAILED;
        end
      end else if (cur_status == LEN_DONE) begin
        // Big-endian length field right after the fixed header, then the
        // byte following the text
        if (idx_c == body_c) begin
          string_length_next = {data_byte, 8'h00};
        end else if (idx_c == body_c + CMP_W'(1)) begin
          string_length_next = {cur_slen[15:8], data_byte};
        end else if (idx_c == body_c + CMP_W'(2) + CMP_W'(cur_slen)) begin
          level_byte_next = data_byte;
        end
      end
      byte_position_next = cur_position + POS_BITS'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Summary for a byte with tlast, taken from the updated state.
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0] size_c;
  logic [CMP_W-1:0] body_r;
  logic [CMP_W-1:0] text_start;
  logic [CMP_W-1:0] text_end;
  logic [3:0]       ptype;
  logic [3:0]       flags;

  always_comb begin
    size_c     = CMP_W'(cur_position) + CMP_W'(1);
    body_r     = CMP_W'(length_bytes_used_next) + CMP_W'(1);
    text_start = body_r + CMP_W'(2);
    text_end   = text_start + CMP_W'(string_length_next);
    ptype      = type_and_flags_next[7:4];
    flags      = type_and_flags_next[3:0];

    result = '0;
    if (cur_matched && cur_position != '0 && ptype != PTYPE_RESERVED &&
        length_status_next == LEN_DONE) begin
      result.accepted         = 1'b1;
      result.packet_type      = ptype;
      result.header_flags     = flags;
      result.remaining_length = length_accumulator_next;

      if (ptype == PTYPE_CONNECT && size_c >= body_r + CMP_W'(4)) begin
        if (text_end <= size_c && string_length_next <= 16'(CONNECT_NAME_MAX)) begin
          result.detail_kind = DETAIL_CONNECT;
          result.text_offset = text_start[2:0];
          result.text_length = string_length_next[7:0];
          if (text_end < size_c) begin
            result.protocol_level = level_byte_next;
            result.level_present  = 1'b1;
          end
        end
      end else if (ptype == PTYPE_PUBLISH && size_c >= body_r + CMP_W'(2)) begin
        if (text_end <= size_c && string_length_next[15:8] == 8'h00) begin
          result.detail_kind = DETAIL_PUBLISH;
          result.text_offset = text_start[2:0];
          result.text_length = string_length_next[7:0];
          result.qos         = flags[2:1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // State registers: advance on every accepted byte.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      port_matched       <= 1'b0;
      type_and_flags     <= 8'h00;
      length_accumulator <= 28'h0;
      length_bytes_used  <= 3'd0;
      length_status      <= LEN_DECODING;
      string_length      <= 16'h0000;
      level_byte         <= 8'h00;
    end else if (in_fire) begin
      byte_position      <= byte_position_next;
      port_matched       <= port_matched_next;
      type_and_flags     <= type_and_flags_next;
      length_accumulator <= length_accumulator_next;
      length_bytes_used  <= length_bytes_used_next;
      length_status      <= length_status_next;
      string_length      <= string_length_next;
      level_byte         <= level_byte_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output buffer. Fill the head first; hold an extra result in the skid
  // entry while the head is stalled, and drain it into the head on a pop.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= result;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'h00,
                     out_data.qos,
                     out_data.protocol_level,
                     out_data.text_length,
                     out_data.text_offset,
                     out_data.remaining_length,
                     out_data.header_flags,
                     out_data.packet_type};
  assign m_tuser  = {out_data.level_present,
                     out_data.detail_kind,
                     out_data.accepted};

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT header parser core testbench
// Streams TCP payload bytes into the core, predicts each per-segment summary
// with a behavioral parser kept in step with every accepted byte, and checks
// every summary transaction field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import mqtt_hp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int unsigned POS_LIMIT = (1 << POS_BITS) - 1;
  localparam int ITEMS_PER_PHASE = 150;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // [7:0] data_byte, [23:8] source_port, [39:24] dest_port
  logic [39:0] s_tdata;
  // [0] first, [1] is_tcp
  logic [1:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  // [3:0] packet_type, [7:4] header_flags, [35:8] remaining_length,
  // [38:36] text_offset, [46:39] text_length, [54:47] protocol_level, [56:55] qos
  logic [63:0] m_tdata;
  // [0] accepted, [2:1] detail_kind, [3] level_present
  logic [3:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mqtt_header_parser_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Port registers as the core should hold them
  logic [15:0] cfg_port_plain = PORT_PLAIN_RST;
  logic [15:0] cfg_port_secure = PORT_SECURE_RST;

  // Segment parse state mirrored from the accepted byte stream
  int unsigned sg_pos;
  bit          sg_port_ok;
  logic [7:0]  sg_first_byte;
  logic [27:0] sg_len_acc;
  int unsigned sg_len_bytes;
  len_status_t sg_len_state;
  logic [15:0] sg_name_len;
  logic [7:0]  sg_level;

  // Summaries predicted for segments whose last byte went in
  result_t header_summaries_due[$];

  logic [7:0] seg_bytes[$];
  int         mismatch_count;
  int         items_sent;
  int         burst_left;
  bit         tx_gaps_on;
  rx_mode_t   rx_mode;
  int         rx_hold_cycles;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count idle cycles while nothing moves; give up past the limit
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[mqtt_header_parser_core] ERROR");
    $finish;
  end

  // Receiver: honor a requested hold, otherwise stall on the chosen pattern
  initial begin : receiver
    logic [15:0] stall_bits;
    int          phase;
    stall_bits = 16'b1101_1001_1110_0110;
    phase = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      phase = (phase + 1) % 16;
      if (rx_hold_cycles > 0) begin
        m_tready = 1'b0;
        rx_hold_cycles--;
      end else begin
        case (rx_mode)
          RX_OPEN:    m_tready = 1'b1;
          RX_RANDOM:  m_tready = ($urandom_range(0, 99) >= 35);
          default:    m_tready = stall_bits[phase];
        endcase
      end
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic compare_field(input string what, input longint unsigned got,
                               input longint unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Check each summary transaction against the oldest prediction
  always @(posedge clk) begin : check_summaries
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (header_summaries_due.size() == 0) begin
        report_mismatch("unexpected summary", m_tdata, 0);
      end else begin
        want = header_summaries_due.pop_front();
        compare_field("accepted", m_tuser[0], want.accepted);
        compare_field("packet_type", m_tdata[3:0], want.packet_type);
        compare_field("header_flags", m_tdata[7:4], want.header_flags);
        compare_field("remaining_length", m_tdata[35:8], want.remaining_length);
        compare_field("detail_kind", m_tuser[2:1], want.detail_kind);
        compare_field("text_offset", m_tdata[38:36], want.text_offset);
        compare_field("text_length", m_tdata[46:39], want.text_length);
        compare_field("protocol_level", m_tdata[54:47], want.protocol_level);
        compare_field("level_present", m_tuser[3], want.level_present);
        compare_field("qos", m_tdata[56:55], want.qos);
      end
    end
  end

  function automatic bit port_hit(input logic [15:0] p);
    return (p == cfg_port_plain) || (p == cfg_port_secure);
  endfunction

  // Advance the mirrored parse by one accepted byte; queue a summary on last
  task automatic predict_header_byte(input logic [7:0] b, input bit first_f, input bit last_f,
                                     input bit tcp, input logic [15:0] sp,
                                     input logic [15:0] dp);
    int unsigned idx, body, size, slen;
    logic [3:0]  ptype;
    result_t     r;
    if (first_f) begin
      sg_pos = 0;
      sg_first_byte = '0;
      sg_len_acc = '0;
      sg_len_bytes = 0;
      sg_len_state = LEN_DECODING;
      sg_name_len = '0;
      sg_level = '0;
      sg_port_ok = tcp && (port_hit(sp) || port_hit(dp));
    end
    idx = sg_pos;
    // Bytes at the saturated position are never captured
    if (idx < POS_LIMIT) begin
      body = 1 + sg_len_bytes;
      if (idx == 0) begin
        sg_first_byte = b;
      end else if (sg_len_state == LEN_DECODING) begin
        sg_len_acc = sg_len_acc + (28'(b[6:0]) << (7 * (sg_len_bytes % 4)));
        sg_len_bytes = (sg_len_bytes + 1) % 8;
        if (!b[7])
          sg_len_state = LEN_DONE;
        else if (sg_len_bytes >= LEN_MAX_BYTES)
          sg_len_state = LEN_FAILED;
      end else if (sg_len_state == LEN_DONE) begin
        if (idx == body)
          sg_name_len = {b, 8'h00};
        else if (idx == body + 1)
          sg_name_len[7:0] = b;
        else if (idx == body + 2 + sg_name_len)
          sg_level = b;
      end
      sg_pos = idx + 1;
    end
    if (last_f) begin
      r = '0;
      size = idx + 1;
      body = 1 + sg_len_bytes;
      slen = sg_name_len;
      ptype = sg_first_byte[7:4];
      if (sg_port_ok && size >= 2 && ptype != PTYPE_RESERVED && sg_len_state == LEN_DONE) begin
        r.accepted = 1'b1;
        r.packet_type = ptype;
        r.header_flags = sg_first_byte[3:0];
        r.remaining_length = sg_len_acc;
        if (ptype == PTYPE_CONNECT && size >= body + 4) begin
          if (body + 2 + slen <= size && slen <= CONNECT_NAME_MAX) begin
            r.detail_kind = DETAIL_CONNECT;
            r.text_offset = 3'(body + 2);
            r.text_length = slen[7:0];
            // Level byte only counts when it lies inside the segment
            if (body + 2 + slen < size) begin
              r.protocol_level = sg_level;
              r.level_present = 1'b1;
            end
          end
        end else if (ptype == PTYPE_PUBLISH && size >= body + 2) begin
          if (body + 2 + slen <= size && slen < 256) begin
            r.detail_kind = DETAIL_PUBLISH;
            r.text_offset = 3'(body + 2);
            r.text_length = slen[7:0];
            r.qos = sg_first_byte[2:1];
          end
        end
      end
      header_summaries_due.push_back(r);
    end
  endtask

  // Offer one byte, idling between bursts, and wait for its transaction
  task automatic send_byte(input logic [7:0] b, input bit first_f, input bit last_f,
                           input bit tcp, input logic [15:0] sp, input logic [15:0] dp);
    int gap;
    if (tx_gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid = 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    s_tdata = {dp, sp, b};
    s_tuser = {tcp, first_f};
    s_tlast = last_f;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_header_byte(b, first_f, last_f, tcp, sp, dp);
    items_sent++;
  endtask

  // Send seg_bytes as one segment; sideband on later bytes is don't-care, so randomize it
  task automatic send_segment(input bit tcp, input logic [15:0] sp, input logic [15:0] dp,
                              input bit mark_first, input bit mark_last);
    foreach (seg_bytes[i]) begin
      if (i == 0)
        send_byte(seg_bytes[i], mark_first, mark_last && seg_bytes.size() == 1, tcp, sp, dp);
      else
        send_byte(seg_bytes[i], 1'b0, mark_last && i == seg_bytes.size() - 1,
                  1'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // Drop valid and wait until every predicted summary has come back
  task automatic wait_quiet();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (header_summaries_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_port_reg(input logic reg_sel, input logic [15:0] value);
    @(negedge clk);
    s_tvalid = 1'b0;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_sel, 2'b00};
    pwdata = {16'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_PORT_PLAIN)
      cfg_port_plain = value;
    else
      cfg_port_secure = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic pick_ports(output bit tcp, output logic [15:0] sp, output logic [15:0] dp);
    int unsigned sel;
    sel = $urandom_range(0, 5);
    tcp = ($urandom_range(0, 11) != 0);
    sp = 16'($urandom);
    dp = 16'($urandom);
    case (sel)
      0:       sp = cfg_port_plain;
      1:       dp = cfg_port_plain;
      2:       sp = cfg_port_secure;
      3, 4:    dp = cfg_port_secure;
      default: ;
    endcase
  endtask

  // Build a mostly well-formed MQTT packet into seg_bytes, sometimes broken
  task automatic build_random_packet();
    int unsigned sel, ptype, rlen, slen, n, keep;
    seg_bytes.delete();
    sel = $urandom_range(0, 9);
    if (sel < 4)
      ptype = PTYPE_CONNECT;
    else if (sel < 7)
      ptype = PTYPE_PUBLISH;
    else
      ptype = $urandom_range(0, 15);
    seg_bytes.push_back({4'(ptype), 4'($urandom)});
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      // remaining length still continuing on its fourth byte
      repeat (LEN_MAX_BYTES) seg_bytes.push_back(8'h80 | 8'($urandom));
    end else begin
      if (sel == 1)
        rlen = 28'hFFF_FFFF;
      else if (sel < 4)
        rlen = $urandom_range(0, 28'hFFF_FFFF);
      else
        rlen = $urandom_range(0, 400);
      do begin
        seg_bytes.push_back({(rlen >= 128) ? 1'b1 : 1'b0, rlen[6:0]});
        rlen = rlen >> 7;
      end while (rlen != 0);
    end
    sel = $urandom_range(0, 9);
    if (ptype == PTYPE_CONNECT)
      slen = (sel < 8) ? $urandom_range(0, CONNECT_NAME_MAX) : $urandom_range(17, 300);
    else if (ptype == PTYPE_PUBLISH)
      slen = (sel < 7) ? $urandom_range(0, 30) :
             (sel < 9) ? $urandom_range(250, 260) : $urandom_range(0, 65535);
    else
      slen = $urandom_range(0, 65535);
    seg_bytes.push_back(slen[15:8]);
    seg_bytes.push_back(slen[7:0]);
    n = slen;
    if (n > 20 && $urandom_range(0, 3) != 0) n = $urandom_range(0, 20);
    if (n > 260) n = 260;
    repeat (n) seg_bytes.push_back(8'($urandom));
    repeat ($urandom_range(0, 3)) seg_bytes.push_back(8'($urandom));
    // cut some packets short anywhere, even inside the fixed header
    if ($urandom_range(0, 4) == 0) begin
      keep = $urandom_range(1, seg_bytes.size());
      while (seg_bytes.size() > keep) void'(seg_bytes.pop_back());
    end
  endtask

  // Bytes before any first mark belong to no matched segment
  task automatic test_before_first();
    seg_bytes = '{8'h10, 8'h02, 8'h00};
    send_segment(1'b1, PORT_PLAIN_RST, PORT_PLAIN_RST, 1'b0, 1'b1);
  endtask

  task automatic test_fixed_headers();
    // CONNECT with level, via the plain port as destination
    seg_bytes = '{8'h10, 8'h0c, 8'h00, 8'h04, 8'h4d, 8'h51, 8'h54, 8'h54, 8'h04};
    send_segment(1'b1, 16'd50000, cfg_port_plain, 1'b1, 1'b1);
    // CONNECT whose name ends the segment: no level byte
    seg_bytes = '{8'h10, 8'h06, 8'h00, 8'h04, 8'h4d, 8'h51, 8'h54, 8'h54};
    send_segment(1'b1, cfg_port_secure, 16'd1, 1'b1, 1'b1);
    // CONNECT name longer than sixteen
    seg_bytes = '{8'h10, 8'h13, 8'h00, 8'h11, 8'h41, 8'h42, 8'h43, 8'h44};
    send_segment(1'b1, 16'd2, cfg_port_plain, 1'b1, 1'b1);
    // CONNECT too short for a name length and one byte
    seg_bytes = '{8'h1f, 8'h02, 8'h00, 8'h04};
    send_segment(1'b1, 16'd2, cfg_port_plain, 1'b1, 1'b1);
    // PUBLISH QoS 2 with a three-byte topic and QoS 3 with an empty topic
    seg_bytes = '{8'h34, 8'h05, 8'h00, 8'h03, 8'h61, 8'h62, 8'h63};
    send_segment(1'b1, 16'd3, cfg_port_secure, 1'b1, 1'b1);
    seg_bytes = '{8'h3f, 8'h02, 8'h00, 8'h00};
    send_segment(1'b1, cfg_port_plain, 16'd3, 1'b1, 1'b1);
    // PUBLISH topic length of 256
    seg_bytes = '{8'h32, 8'h04, 8'h01, 8'h00, 8'h61, 8'h62};
    send_segment(1'b1, 16'd3, cfg_port_plain, 1'b1, 1'b1);
    // reserved type 0, type 15, a single byte, not TCP, no port match
    seg_bytes = '{8'h00, 8'h00};
    send_segment(1'b1, 16'd4, cfg_port_plain, 1'b1, 1'b1);
    seg_bytes = '{8'hf0, 8'h00};
    send_segment(1'b1, 16'd4, cfg_port_plain, 1'b1, 1'b1);
    seg_bytes = '{8'h30};
    send_segment(1'b1, 16'd4, cfg_port_plain, 1'b1, 1'b1);
    seg_bytes = '{8'h30, 8'h00};
    send_segment(1'b0, cfg_port_plain, cfg_port_secure, 1'b1, 1'b1);
    send_segment(1'b1, 16'hffff, 16'h0000, 1'b1, 1'b1);
  endtask

  task automatic test_length_encoding();
    // largest four-byte length, fourth byte still continuing, unfinished
    seg_bytes = '{8'h30, 8'hff, 8'hff, 8'hff, 8'h7f};
    send_segment(1'b1, 16'd5, cfg_port_plain, 1'b1, 1'b1);
    seg_bytes = '{8'h30, 8'h80, 8'h80, 8'h80, 8'h80};
    send_segment(1'b1, 16'd5, cfg_port_plain, 1'b1, 1'b1);
    seg_bytes = '{8'h30, 8'h80};
    send_segment(1'b1, 16'd5, cfg_port_plain, 1'b1, 1'b1);
    // two-byte length shifts the topic offset
    seg_bytes = '{8'h32, 8'h80, 8'h01, 8'h00, 8'h02, 8'h41, 8'h42};
    send_segment(1'b1, 16'd5, cfg_port_plain, 1'b1, 1'b1);
  endtask

  // Segment without last keeps going; bytes after last extend the old segment
  task automatic test_segment_continuation();
    seg_bytes = '{8'h30, 8'h00};
    send_segment(1'b1, cfg_port_plain, 16'd6, 1'b1, 1'b0);
    seg_bytes = '{8'h00, 8'h01};
    send_segment(1'b0, 16'd0, 16'd0, 1'b0, 1'b1);
    seg_bytes = '{8'hff};
    send_segment(1'b0, 16'd0, 16'd0, 1'b0, 1'b1);
  endtask

  // Hold the receiver off so the output buffer fills and the input stalls
  task automatic test_output_backpressure();
    tx_gaps_on = 1'b0;
    rx_hold_cycles = 300;
    repeat (30) begin
      seg_bytes = '{8'h30, 8'h00};
      send_segment(1'b1, cfg_port_plain, 16'd8, 1'b1, 1'b1);
    end
    wait_quiet();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    bit          tcp;
    logic [15:0] sp, dp;
    int          sel, phase_end;
    for (int phase = 0; phase < 5; phase++) begin
      wait_quiet();
      case (phase)
        0: begin
          write_port_reg(REG_PORT_PLAIN, 16'h0000);
          write_port_reg(REG_PORT_SECURE, 16'hffff);
        end
        1: begin
          write_port_reg(REG_PORT_PLAIN, 16'hffff);
          write_port_reg(REG_PORT_SECURE, 16'h0000);
        end
        2: begin
          sp = 16'($urandom);
          write_port_reg(REG_PORT_PLAIN, sp);
          write_port_reg(REG_PORT_SECURE, sp);
        end
        3: begin
          write_port_reg(REG_PORT_PLAIN, 16'($urandom));
          write_port_reg(REG_PORT_SECURE, 16'($urandom));
        end
        default: begin
          write_port_reg(REG_PORT_SECURE, PORT_SECURE_RST);
          write_port_reg(REG_PORT_PLAIN, PORT_PLAIN_RST);
        end
      endcase
      rx_mode = rx_mode_t'(phase % 3);
      tx_gaps_on = (phase != 1);
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        sel = $urandom_range(0, 99);
        if (sel < 78) begin
          build_random_packet();
          pick_ports(tcp, sp, dp);
          send_segment(tcp, sp, dp, 1'b1, sel >= 8);
        end else if (sel < 86) begin
          // trailing bytes with no first mark
          repeat ($urandom_range(1, 3))
            send_byte(8'($urandom), 1'b0, 1'($urandom), 1'($urandom), 16'($urandom),
                      16'($urandom));
        end else if (sel < 96) begin
          repeat ($urandom_range(1, 8))
            send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                      1'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          wait_quiet();
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatch_count = 0;
    items_sent = 0;
    burst_left = 0;
    tx_gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    rx_hold_cycles = 0;
    sg_pos = 0;
    sg_port_ok = 1'b0;
    sg_first_byte = '0;
    sg_len_acc = '0;
    sg_len_bytes = 0;
    sg_len_state = LEN_DECODING;
    sg_name_len = '0;
    sg_level = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_before_first();
    test_fixed_headers();
    test_length_encoding();
    test_segment_continuation();
    test_output_backpressure();
    test_random_traffic();

    wait_quiet();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("[mqtt_header_parser_core] OK");
    else
      $display("[mqtt_header_parser_core] ERROR");
    $finish;
  end

endmodule
